/* rtl/cld_pkg.sv */
// Shared types and constants for the text command line decoder.
// Holds the command class codes, the character codes and the pattern tables.
// No dependencies; cld_decode and the top level refer to it by scoped names.
package cld_pkg;

  // Command class reported with each completed line.
  typedef enum logic [2:0] {
    CLS_LOG     = 3'd0,
    CLS_OFF     = 3'd1,
    CLS_STOP    = 3'd2,
    CLS_START   = 3'd3,
    CLS_SCALE_F = 3'd4,
    CLS_SCALE_C = 3'd5,
    CLS_PERIOD  = 3'd6,
    CLS_UNREC   = 3'd7
  } cld_class_t;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_EOT  = 8'h04;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int unsigned NUM_PAT = 7;
  localparam int unsigned PAT_MAX = 7;

  // Pattern index order: LOG, OFF, STOP, START, SCALE=F, SCALE=C, PERIOD=.
  localparam int unsigned PAT_LOG     = 0;
  localparam int unsigned PAT_OFF     = 1;
  localparam int unsigned PAT_STOP    = 2;
  localparam int unsigned PAT_START   = 3;
  localparam int unsigned PAT_SCALE_F = 4;
  localparam int unsigned PAT_SCALE_C = 5;
  localparam int unsigned PAT_PERIOD  = 6;

  localparam logic [7:0] PAT_TEXT [NUM_PAT][PAT_MAX] = '{
    '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "R", "T", 8'h00, 8'h00},
    '{"S", "C", "A", "L", "E", "=", "F"},
    '{"S", "C", "A", "L", "E", "=", "C"},
    '{"P", "E", "R", "I", "O", "D", "="}
  };

  localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
    4'd3, 4'd3, 4'd4, 4'd5, 4'd7, 4'd7, 4'd7
  };

  localparam logic [3:0] POS_MAX     = 4'd15;
  localparam logic [3:0] DIGIT_START = 4'd7;
  localparam logic [3:0] LOG_MIN     = 4'd3;
  localparam logic [3:0] PERIOD_MIN  = 4'd8;

  // Status of the byte at the decoder input, passed to the top level.
  typedef struct packed {
    logic       produce;   // this byte completes a line and yields a transaction
    logic       halted;    // decoder has seen OFF and ignores all bytes
    cld_class_t cls;
    logic       run;
    logic       celsius;
  } cld_status_t;

endpackage

/* rtl/cld_byte_if.sv */
// Input channel interface: one received ASCII byte per transaction.
// Depends on nothing.
interface cld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/cld_result_if.sv */
// Result channel interface: command class and live settings per completed line.
// Depends on nothing; PERIOD_WIDTH must match the decoder's parameter.
interface cld_result_if #(
  parameter int unsigned PERIOD_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              command_class;
  logic                    run_enable;
  logic                    celsius_selected;
  logic [PERIOD_WIDTH-1:0] period_value;

  modport source (output valid, output command_class, output run_enable,
                  output celsius_selected, output period_value, input ready);
  modport sink   (input valid, input command_class, input run_enable,
                  input celsius_selected, input period_value, output ready);
endinterface

/* rtl/cld_decode.sv */
// Line state and live settings of the command line decoder, one byte per cycle while en is high.
// Depends on cld_pkg for the pattern tables, class codes and status struct.
module cld_decode #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [7:0]                byte_val,
  output cld_pkg::cld_status_t      st,
  output logic [PERIOD_WIDTH-1:0]   period_o
);

  localparam int unsigned PW = PERIOD_WIDTH;

  logic [3:0]                  pos_r, pos_nxt;
  logic [cld_pkg::NUM_PAT-1:0] flags_r, flags_nxt;
  logic [PW-1:0]               acc_r, acc_nxt;
  logic                        ended_r, ended_nxt;
  logic                        run_r, run_nxt;
  logic                        cel_r, cel_nxt;
  logic [PW-1:0]               per_r, per_nxt;
  logic                        halted_r, halted_nxt;

  logic                        drop;
  logic                        is_lf;
  logic                        is_digit;
  logic [PW+3:0]               prod;
  cld_pkg::cld_class_t         cls;

  // Classification of the line collected so far, in priority order.
  always_comb begin
    priority if (flags_r[cld_pkg::PAT_LOG] && pos_r >= cld_pkg::LOG_MIN) begin
      cls = cld_pkg::CLS_LOG;
    end else if (flags_r[cld_pkg::PAT_OFF] &&
                 pos_r == cld_pkg::PAT_LEN[cld_pkg::PAT_OFF]) begin
      cls = cld_pkg::CLS_OFF;
    end else if (flags_r[cld_pkg::PAT_STOP] &&
                 pos_r == cld_pkg::PAT_LEN[cld_pkg::PAT_STOP]) begin
      cls = cld_pkg::CLS_STOP;
    end else if (flags_r[cld_pkg::PAT_START] &&
                 pos_r == cld_pkg::PAT_LEN[cld_pkg::PAT_START]) begin
      cls = cld_pkg::CLS_START;
    end else if (flags_r[cld_pkg::PAT_SCALE_F] &&
                 pos_r == cld_pkg::PAT_LEN[cld_pkg::PAT_SCALE_F]) begin
      cls = cld_pkg::CLS_SCALE_F;
    end else if (flags_r[cld_pkg::PAT_SCALE_C] &&
                 pos_r == cld_pkg::PAT_LEN[cld_pkg::PAT_SCALE_C]) begin
      cls = cld_pkg::CLS_SCALE_C;
    end else if (flags_r[cld_pkg::PAT_PERIOD] && pos_r >= cld_pkg::PERIOD_MIN) begin
      cls = cld_pkg::CLS_PERIOD;
    end else begin
      cls = cld_pkg::CLS_UNREC;
    end
  end

  assign drop     = halted_r || byte_val == cld_pkg::CHAR_NUL ||
                    byte_val == cld_pkg::CHAR_EOT;
  assign is_lf    = byte_val == cld_pkg::CHAR_LF;
  assign is_digit = byte_val >= cld_pkg::CHAR_ZERO && byte_val <= cld_pkg::CHAR_NINE;
  // Times ten as two shifts and an add, plus the new digit.
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
              + (PW+4)'(byte_val[3:0]);

  always_comb begin
    pos_nxt    = pos_r;
    flags_nxt  = flags_r;
    acc_nxt    = acc_r;
    ended_nxt  = ended_r;
    run_nxt    = run_r;
    cel_nxt    = cel_r;
    per_nxt    = per_r;
    halted_nxt = halted_r;

    if (!drop && !is_lf) begin
      for (int k = 0; k < cld_pkg::NUM_PAT; k++) begin
        if (pos_r < cld_pkg::PAT_LEN[k] &&
            cld_pkg::PAT_TEXT[k][pos_r[2:0]] != byte_val) begin
          flags_nxt[k] = 1'b0;
        end
      end
      if (pos_r >= cld_pkg::DIGIT_START && !ended_r) begin
        if (is_digit) begin
          acc_nxt = (prod > {4'b0, {PW{1'b1}}}) ? {PW{1'b1}} : prod[PW-1:0];
        end else begin
          ended_nxt = 1'b1;
        end
      end
      if (pos_r != cld_pkg::POS_MAX) begin
        pos_nxt = pos_r + 4'd1;
      end
    end

    if (!drop && is_lf) begin
      unique case (cls)
        cld_pkg::CLS_OFF: begin
          run_nxt    = 1'b0;
          halted_nxt = 1'b1;
        end
        cld_pkg::CLS_STOP:    run_nxt = 1'b0;
        cld_pkg::CLS_START:   run_nxt = 1'b1;
        cld_pkg::CLS_SCALE_F: cel_nxt = 1'b0;
        cld_pkg::CLS_SCALE_C: cel_nxt = 1'b1;
        cld_pkg::CLS_PERIOD:  per_nxt = acc_r;
        default: begin
        end
      endcase
      pos_nxt   = '0;
      flags_nxt = '1;
      acc_nxt   = '0;
      ended_nxt = 1'b0;
    end

    st.produce = !drop && is_lf;
    st.halted  = halted_r;
    st.cls     = cls;
    st.run     = run_nxt;
    st.celsius = cel_nxt;
    period_o   = per_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      flags_r  <= '1;
      acc_r    <= '0;
      ended_r  <= 1'b0;
      run_r    <= 1'b1;
      cel_r    <= 1'b0;
      per_r    <= PW'(1);
      halted_r <= 1'b0;
    end else if (en) begin
      pos_r    <= pos_nxt;
      flags_r  <= flags_nxt;
      acc_r    <= acc_nxt;
      ended_r  <= ended_nxt;
      run_r    <= run_nxt;
      cel_r    <= cel_nxt;
      per_r    <= per_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* rtl/text_command_line_decoder.sv */
// Top level of the sensor node text command line decoder.
// Depends on cld_pkg, cld_byte_if, cld_result_if and cld_decode.
//
//   Channel | Direction | Transaction carries
//   --------+-----------+---------------------------------------------------
//   in_ch   | sink      | in_byte: one received ASCII byte
//   out_ch  | source    | command_class, run_enable, celsius_selected,
//           |           | period_value: one per completed command line
//
// A byte accepted into the input register is decoded from it, and when it ends a line
// its transaction loads the output register; while the input is not held up, one byte is
// taken every cycle. The input is held up only when a line ends while an earlier
// transaction still waits in the output register.
// Reset is synchronous and active low: the line state clears, running is on,
// Fahrenheit is selected and the period value is one.

module text_command_line_decoder #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  cld_byte_if.sink            in_ch,
  cld_result_if.source        out_ch
);

  localparam int unsigned PW = PERIOD_WIDTH;

  // Input register: holds one byte until the decoder has consumed it.
  logic       byte_vld_r, byte_vld_nxt;
  logic [7:0] byte_r;

  // Output register: the transaction offered on the result channel.
  logic                out_vld_r, out_vld_nxt;
  cld_pkg::cld_class_t cls_r;
  logic                run_r;
  logic                cel_r;
  logic [PW-1:0]       per_r;

  cld_pkg::cld_status_t st;
  logic [PW-1:0]        per_dec;
  logic                 advance;
  logic                 load_out;
  logic                 in_take;

  // The decoder consumes the held byte unless that byte ends a line while the
  // output register is still occupied and not being emptied this cycle.
  assign advance  = byte_vld_r &&
                    (!st.produce || !out_vld_r || out_ch.ready);
  assign load_out = advance && st.produce;
  assign in_take  = in_ch.valid && in_ch.ready;

  // A new byte can enter whenever the held byte is gone or leaves this cycle.
  assign in_ch.ready = !byte_vld_r || advance;

  cld_decode #(
    .PERIOD_WIDTH (PW)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .byte_val (byte_r),
    .st       (st),
    .period_o (per_dec)
  );

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_take) begin
      byte_vld_nxt = 1'b1;
    end else if (advance) begin
      byte_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers need no reset; they are qualified by the valid flags.
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.in_byte;
    end
    if (load_out) begin
      cls_r <= st.cls;
      run_r <= st.run;
      cel_r <= st.celsius;
      per_r <= per_dec;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.command_class    = cls_r;
  assign out_ch.run_enable       = run_r;
  assign out_ch.celsius_selected = cel_r;
  assign out_ch.period_value     = per_r;

  // Once halted, the decoder must never produce another transaction.
  a_halt_silent : assert property (@(posedge clk) disable iff (!rst_n)
    st.halted |-> !st.produce)
    else $error("decoder produced a transaction while halted");

  // An OFF line always reports the run flag as cleared.
  a_off_stops : assert property (@(posedge clk) disable iff (!rst_n)
    (st.produce && st.cls == cld_pkg::CLS_OFF) |-> !st.run)
    else $error("OFF line reported with running still enabled");

  // A new transaction never overwrites one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_vld_r && !out_ch.ready))
    else $error("output register overwritten while stalled");

endmodule
